// File: rtl/core/tscan_pkg.sv
// tscan_pkg: types, token codes and character tables of the token scanner.
// Used by every file in rtl/core; depends on nothing.
`timescale 1ns / 1ps

package tscan_pkg;

  localparam int unsigned MAX_LEXEME  = 64;
  localparam int unsigned MAX_COLUMNS = 1024;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned CODE_W     = 5;
  localparam int unsigned LEN_W      = $clog2(MAX_LEXEME + 1);
  localparam int unsigned COL_W      = $clog2(MAX_COLUMNS);
  localparam int unsigned MAX_TOKENS = 3;
  localparam int unsigned CNT_W      = 2;
  localparam int unsigned NUM_KEYS   = 5;
  localparam int unsigned KEY_MAX    = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  // token codes
  localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 5'd0;
  localparam logic [CODE_W-1:0] CODE_IDENT    = 5'd1;
  localparam logic [CODE_W-1:0] CODE_CONST    = 5'd2;
  localparam logic [CODE_W-1:0] CODE_ADD      = 5'd3;
  localparam logic [CODE_W-1:0] CODE_SUB      = 5'd4;
  localparam logic [CODE_W-1:0] CODE_MUL      = 5'd5;
  localparam logic [CODE_W-1:0] CODE_DIV      = 5'd6;
  localparam logic [CODE_W-1:0] CODE_LPAREN   = 5'd7;
  localparam logic [CODE_W-1:0] CODE_RPAREN   = 5'd8;
  localparam logic [CODE_W-1:0] CODE_LBRACKET = 5'd9;
  localparam logic [CODE_W-1:0] CODE_RBRACKET = 5'd10;
  localparam logic [CODE_W-1:0] CODE_LBRACE   = 5'd11;
  localparam logic [CODE_W-1:0] CODE_RBRACE   = 5'd12;
  localparam logic [CODE_W-1:0] CODE_SEMI     = 5'd13;
  localparam logic [CODE_W-1:0] CODE_COMMA    = 5'd14;
  localparam logic [CODE_W-1:0] CODE_DOT      = 5'd15;
  localparam logic [CODE_W-1:0] CODE_KEY_MAIN = 5'd16;

  // keywords: main int string public cout
  localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{3'd4, 3'd3, 3'd6, 3'd6, 3'd4};
  localparam logic [CH_W-1:0] KEY_TEXT [NUM_KEYS][KEY_MAX] = '{
    '{"m", "a", "i", "n", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"s", "t", "r", "i", "n", "g"},
    '{"p", "u", "b", "l", "i", "c"},
    '{"c", "o", "u", "t", 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic [COL_W-1:0]  column;
  } token_t;

  // all tokens caused by one item, in order; count is never zero in the queue
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic   [CNT_W-1:0]      count;
  } group_t;

  // per-keyword flag: keyword k has character c at position pos
  function automatic logic [NUM_KEYS-1:0] key_match(logic [2:0] pos, logic pos_short,
                                                   logic [CH_W-1:0] c);
    logic [NUM_KEYS-1:0] m;
    m = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      m[k] = pos_short && (pos < KEY_LEN[k]) && (pos < 3'(KEY_MAX)) &&
             (KEY_TEXT[k][pos] == c);
    end
    return m;
  endfunction

  function automatic logic [CODE_W-1:0] single_code(logic [CH_W-1:0] c);
    logic [CODE_W-1:0] code;
    case (c)
      "+":     code = CODE_ADD;
      "-":     code = CODE_SUB;
      "*":     code = CODE_MUL;
      "/":     code = CODE_DIV;
      "(":     code = CODE_LPAREN;
      ")":     code = CODE_RPAREN;
      "[":     code = CODE_LBRACKET;
      "]":     code = CODE_RBRACKET;
      "{":     code = CODE_LBRACE;
      "}":     code = CODE_RBRACE;
      ";":     code = CODE_SEMI;
      ",":     code = CODE_COMMA;
      ".":     code = CODE_DOT;
      default: code = CODE_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/tscan_in_if.sv
// tscan_in_if: character channel (valid/ready plus one character item).
// Depends on tscan_pkg for field widths.
`timescale 1ns / 1ps

interface tscan_in_if;
  logic                      valid;
  logic                      ready;
  logic [tscan_pkg::CH_W-1:0] ch;
  logic                      end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

// File: rtl/core/tscan_out_if.sv
// tscan_out_if: token channel (valid/ready plus one token item).
// Depends on tscan_pkg for field widths.
`timescale 1ns / 1ps

interface tscan_out_if;
  logic                        valid;
  logic                        ready;
  logic [tscan_pkg::CODE_W-1:0] token_code;
  logic [tscan_pkg::LEN_W-1:0]  token_length;
  logic [tscan_pkg::COL_W-1:0]  start_column;
  logic                        last;

  modport source (output valid, output token_code, output token_length,
                  output start_column, output last, input ready);
  modport sink   (input valid, input token_code, input token_length,
                  input start_column, input last, output ready);
endinterface

// File: rtl/core/tscan_front.sv
// tscan_front: scanner state machine; classifies each character item and
// builds the group of tokens it completes. Depends on tscan_pkg, tscan_in_if.
`timescale 1ns / 1ps

module tscan_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tscan_in_if.sink          in_i,
  input  logic              space_i,
  output logic              push_o,
  output tscan_pkg::group_t group_o
);
  import tscan_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEXEME + 1);
  localparam int unsigned CW = $clog2(MAX_COLUMNS);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_IDENT = 3'b010,
    MODE_CONST = 3'b100
  } scan_mode_e;

  scan_mode_e          mode_q, mode_d;
  logic [NUM_KEYS-1:0] hits_q, hits_d;
  logic [LW-1:0]       len_q, len_d;
  logic [CW-1:0]       start_q, start_d;
  logic [CW-1:0]       col_q, col_d;
  logic                used_q, used_d;
  logic                pend_q, pend_d;
  group_t              grp;
  logic                accept;

  function automatic logic is_lower(logic [CH_W-1:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic is_digit(logic [CH_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_space(logic [CH_W-1:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic ident_cont(logic [CH_W-1:0] c);
    return is_lower(c) || ((c >= "A") && (c <= "Z")) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic [LW-1:0] sat_add(logic [LW-1:0] a, logic [1:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + (LW + 1)'(b);
    return (s > (LW + 1)'(MAX_LEXEME)) ? LW'(MAX_LEXEME) : s[LW-1:0];
  endfunction

  // first keyword whose flags survived and whose length matches
  function automatic logic [CODE_W-1:0] ident_code(logic [NUM_KEYS-1:0] hits,
                                                   logic [LW-1:0] len);
    logic [CODE_W-1:0] code;
    code = CODE_IDENT;
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (hits[k] && (len == LW'(KEY_LEN[k]))) begin
        code = CODE_KEY_MAIN + CODE_W'(k);
      end
    end
    return code;
  endfunction

  assign accept   = in_i.valid && space_i;
  assign in_i.ready = space_i;

  always_comb begin : scan_logic
    logic             consumed;
    logic [CW-1:0]    prev_col;
    logic [CNT_W-1:0] n;
    logic [CH_W-1:0]  c;
    c        = in_i.ch;
    mode_d   = mode_q;
    hits_d   = hits_q;
    len_d    = len_q;
    start_d  = start_q;
    col_d    = col_q;
    used_d   = used_q;
    pend_d   = pend_q;
    consumed = 1'b0;
    n        = '0;
    grp      = '0;
    prev_col = (col_q == '0) ? '0 : col_q - 1'b1;

    unique case (mode_q)
      MODE_IDENT: begin
        if (ident_cont(c)) begin
          hits_d   = hits_q & key_match(len_q[2:0], len_q < LW'(8), c);
          len_d    = sat_add(len_q, 2'd1);
          consumed = 1'b1;
        end else begin
          grp.tok[n] = '{code: ident_code(hits_q, len_q), length: LEN_W'(len_q),
                         column: COL_W'(start_q)};
          n      = n + 1'b1;
          mode_d = MODE_IDLE;
          pend_d = 1'b0;
          used_d = 1'b0;
        end
      end
      MODE_CONST: begin
        if (is_digit(c)) begin
          if (pend_q) begin
            len_d  = sat_add(len_q, 2'd2);
            used_d = 1'b1;
            pend_d = 1'b0;
          end else begin
            len_d = sat_add(len_q, 2'd1);
          end
          consumed = 1'b1;
        end else if ((c == ".") && !used_q && !pend_q) begin
          pend_d   = 1'b1;
          consumed = 1'b1;
        end else begin
          grp.tok[n] = '{code: CODE_CONST, length: LEN_W'(len_q), column: COL_W'(start_q)};
          n = n + 1'b1;
          if (pend_q) begin
            // held point that no digit followed
            grp.tok[n] = '{code: CODE_DOT, length: LEN_W'(1), column: COL_W'(prev_col)};
            n = n + 1'b1;
          end
          mode_d = MODE_IDLE;
          pend_d = 1'b0;
          used_d = 1'b0;
        end
      end
      default: mode_d = MODE_IDLE;
    endcase

    if (!consumed && !is_space(c)) begin
      if (is_lower(c)) begin
        mode_d  = MODE_IDENT;
        start_d = col_q;
        len_d   = LW'(1);
        hits_d  = key_match(3'd0, 1'b1, c);
      end else if (is_digit(c)) begin
        mode_d  = MODE_CONST;
        start_d = col_q;
        len_d   = LW'(1);
        used_d  = 1'b0;
        pend_d  = 1'b0;
      end else begin
        grp.tok[n] = '{code: single_code(c), length: LEN_W'(1), column: COL_W'(col_q)};
        n = n + 1'b1;
      end
    end

    if (in_i.end_of_line) begin
      if (mode_d == MODE_IDENT) begin
        grp.tok[n] = '{code: ident_code(hits_d, len_d), length: LEN_W'(len_d),
                       column: COL_W'(start_d)};
        n = n + 1'b1;
      end else if (mode_d == MODE_CONST) begin
        grp.tok[n] = '{code: CODE_CONST, length: LEN_W'(len_d), column: COL_W'(start_d)};
        n = n + 1'b1;
        if (pend_d) begin
          grp.tok[n] = '{code: CODE_DOT, length: LEN_W'(1), column: COL_W'(col_q)};
          n = n + 1'b1;
        end
      end
      mode_d = MODE_IDLE;
      pend_d = 1'b0;
      used_d = 1'b0;
      col_d  = '0;
    end else if (col_q < CW'(MAX_COLUMNS - 1)) begin
      col_d = col_q + 1'b1;
    end

    grp.count = n;
  end

  assign push_o  = accept && (grp.count != '0);
  assign group_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      hits_q  <= '1;
      len_q   <= '0;
      start_q <= '0;
      col_q   <= '0;
      used_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else if (accept) begin
      mode_q  <= mode_d;
      hits_q  <= hits_d;
      len_q   <= len_d;
      start_q <= start_d;
      col_q   <= col_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// File: rtl/core/tscan_queue.sv
// tscan_queue: short register FIFO of token groups between front and back.
// Depends on tscan_pkg.
`timescale 1ns / 1ps

module tscan_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tscan_pkg::group_t data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              space_o,
  output tscan_pkg::group_t head_o
);
  import tscan_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  group_t        mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [NW-1:0] cnt_q;
  logic          do_pop;

  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q < NW'(DEPTH));
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/tscan_back.sv
// tscan_back: walks the head group of the queue and hands out one token item
// per cycle while out_o.ready is high. Depends on tscan_pkg, tscan_out_if.
`timescale 1ns / 1ps

module tscan_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tscan_pkg::group_t head_i,
  output logic              pop_o,
  tscan_out_if.source       out_o
);
  import tscan_pkg::*;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic             is_last;
  logic             fire;
  token_t           cur;

  assign cur     = head_i.tok[idx_q];
  assign is_last = (idx_q == head_i.count - 1'b1);
  assign fire    = valid_i && out_o.ready;
  assign pop_o   = fire && is_last;

  assign out_o.valid        = valid_i;
  assign out_o.token_code   = cur.code;
  assign out_o.token_length = cur.length;
  assign out_o.start_column = cur.column;
  assign out_o.last         = is_last;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// File: rtl/core/token_scanner_unit.sv
// token_scanner_unit: top level of the streaming token scanner.
// Depends on tscan_pkg, tscan_in_if, tscan_out_if, tscan_front, tscan_queue, tscan_back.
`timescale 1ns / 1ps

// Usage
// - in_i carries one source character per item (ch, end_of_line). out_o carries
//   one token per item (token_code, token_length, start_column, last). Both use
//   valid/ready; an item moves on a rising edge with valid and ready high.
// - A token is completed by the character after it, or by end_of_line on its
//   own last character. One character item completes 0 to 3 tokens; last marks
//   the final token of that group.
// - A group is written to the queue when its character is taken; its first
//   token is valid once older groups leave; then one per cycle while ready.
// - Throughput: one character per cycle while the queue has room. A character
//   that completes k tokens occupies the output for k token items; the front
//   keeps taking characters meanwhile until the two-group queue is full.
// - Receiver stall: groups collect in the queue; in_i.ready drops only when the
//   queue holds two groups, and rises again as soon as one has left.
// - Reset (rst_ni low, asynchronous): scanner goes idle at column 0, queue is
//   emptied, no token is valid. Nothing else needs initializing.
// - MAX_LEXEME (package) sets where token lengths saturate; MAX_COLUMNS sets the
//   column counter range (the column saturates at MAX_COLUMNS-1 on a long line).

module token_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  tscan_in_if.sink    in_i,
  tscan_out_if.source out_o
);
  import tscan_pkg::*;

  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  logic   q_space;
  group_t q_in;
  group_t q_head;

  // front: scanner state and token grouping, one character per cycle when queue has room
  tscan_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .space_i(q_space),
    .push_o (q_push),
    .group_o(q_in)
  );

  // queue decouples scanning from the output handshake
  tscan_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .space_o(q_space),
    .head_o (q_head)
  );

  // back: serializes a group into token items
  tscan_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(q_valid),
    .head_i (q_head),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

  // a group is only pushed when the queue has room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_space)
    else $error("token group pushed into a full queue");

  // a queued group always holds at least one token
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid |-> (q_head.count != '0))
    else $error("empty token group at queue head");

  // the group leaves the queue exactly when its last token is taken
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop == (out_o.valid && out_o.ready && out_o.last))
    else $error("queue pop out of step with last token");

endmodule

// File: tb/tb.sv
// tb: self-checking bench for token_scanner_unit; streams characters in, checks every token.
// Depends on tscan_pkg, tscan_in_if, tscan_out_if and the token_scanner_unit RTL.
`timescale 1ns / 1ps

module tb;
  import tscan_pkg::*;

  localparam int STALL_LIMIT   = 3000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES   = 60;    // long receiver hold-off to back up the queue
  localparam int TAIL_CYCLES   = 10;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [CODE_W-1:0] CODE_KEY_INT = CODE_KEY_MAIN + 5'd1;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUMBER} scan_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
    logic [COL_W-1:0]  column;
    logic              last;
  } token_rec_t;

  // one character item; known rows carry tokens typed in by hand
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             eol;
    logic             known;
    logic [1:0]       n;
    token_rec_t [2:0] toks;
  } char_row_t;

  localparam token_rec_t NO_TOK = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tscan_in_if  chars_if ();
  tscan_out_if tokens_if ();

  token_scanner_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (chars_if),
    .out_o (tokens_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  string keyword_text [NUM_KEYS] = '{"main", "int", "string", "public", "cout"};
  string single_set = "+-*/()[]{};,.";
  string odd_set    = "+-*/()[]{};,._AZ~@";

  // scanner state as the predictor tracks it
  scan_e               scan_mode_q = SCAN_IDLE;
  logic [NUM_KEYS-1:0] key_hits    = '1;
  logic [LEN_W-1:0]    lex_len     = '0;
  logic [COL_W-1:0]    tok_start   = '0;
  logic [COL_W-1:0]    col_next    = '0;
  logic                point_used  = 1'b0;
  logic                point_held  = 1'b0;

  token_rec_t step_toks [3];
  int         step_n;
  token_rec_t tokens_owed [$];

  int send_idle_pct;
  int recv_stall_pct;
  int eol_pct = 10;
  int items_sent;
  int mismatch_count;
  int hold_req, hold_ack, hold_left;
  int stall_cycles;

  // ---------------------------------------------------------------- predictor

  function automatic logic is_lower(logic [CH_W-1:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic logic is_digit(logic [CH_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [CH_W-1:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic word_char(logic [CH_W-1:0] c);
    return is_lower(c) || (c >= "A" && c <= "Z") || is_digit(c) || c == "_";
  endfunction

  function automatic logic [CODE_W-1:0] char_code(logic [CH_W-1:0] c);
    for (int i = 0; i < single_set.len(); i++)
      if (single_set[i] == c) return CODE_W'(CODE_ADD + i);
    return CODE_UNKNOWN;
  endfunction

  // drop keywords whose character at pos differs from c
  function automatic logic [NUM_KEYS-1:0] hits_after(logic [NUM_KEYS-1:0] hits, int pos,
                                                    logic [CH_W-1:0] c);
    for (int k = 0; k < NUM_KEYS; k++)
      if (!(pos < keyword_text[k].len() && keyword_text[k][pos] == c)) hits[k] = 1'b0;
    return hits;
  endfunction

  function automatic logic [LEN_W-1:0] len_add(logic [LEN_W-1:0] len, int inc);
    int s;
    s = len + inc;
    return (s > MAX_LEXEME) ? LEN_W'(MAX_LEXEME) : LEN_W'(s);
  endfunction

  task automatic add_token(logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                           logic [COL_W-1:0] col);
    step_toks[step_n] = '{code, len, col, 1'b0};
    step_n++;
  endtask

  // close the word or number in progress; a held point becomes its own DOT
  task automatic finish_token(logic [COL_W-1:0] dot_col);
    logic [CODE_W-1:0] code;
    if (scan_mode_q == SCAN_WORD) begin
      code = CODE_IDENT;
      for (int k = 0; k < NUM_KEYS; k++) begin
        if (key_hits[k] && lex_len == keyword_text[k].len()) begin
          code = CODE_W'(CODE_KEY_MAIN + k);
          break;
        end
      end
      add_token(code, lex_len, tok_start);
    end else if (scan_mode_q == SCAN_NUMBER) begin
      add_token(CODE_CONST, lex_len, tok_start);
      if (point_held) add_token(CODE_DOT, LEN_W'(1), dot_col);
    end
    scan_mode_q = SCAN_IDLE;
    point_held  = 1'b0;
    point_used  = 1'b0;
  endtask

  // advance the scanner by one character; tokens land in step_toks
  task automatic scan_char(logic [CH_W-1:0] c, logic eol);
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] prev_col;
    logic             taken;
    col      = col_next;
    prev_col = (col != 0) ? col - 1'b1 : '0;
    taken    = 1'b0;
    step_n   = 0;
    case (scan_mode_q)
      SCAN_WORD: begin
        if (word_char(c)) begin
          key_hits = hits_after(key_hits, lex_len, c);
          lex_len  = len_add(lex_len, 1);
          taken    = 1'b1;
        end else begin
          finish_token(prev_col);
        end
      end
      SCAN_NUMBER: begin
        if (is_digit(c)) begin
          if (point_held) begin
            // held point plus this digit join the constant together
            lex_len    = len_add(lex_len, 2);
            point_used = 1'b1;
            point_held = 1'b0;
          end else begin
            lex_len = len_add(lex_len, 1);
          end
          taken = 1'b1;
        end else if (c == "." && !point_used && !point_held) begin
          point_held = 1'b1;
          taken      = 1'b1;
        end else begin
          finish_token(prev_col);
        end
      end
      default: scan_mode_q = SCAN_IDLE;
    endcase
    if (!taken && !is_blank(c)) begin
      if (is_lower(c)) begin
        scan_mode_q = SCAN_WORD;
        tok_start   = col;
        lex_len     = LEN_W'(1);
        key_hits    = hits_after('1, 0, c);
      end else if (is_digit(c)) begin
        scan_mode_q = SCAN_NUMBER;
        tok_start   = col;
        lex_len     = LEN_W'(1);
        point_used  = 1'b0;
        point_held  = 1'b0;
      end else begin
        add_token(char_code(c), LEN_W'(1), col);
      end
    end
    if (eol) begin
      finish_token(col);
      col_next = '0;
    end else if (col_next < MAX_COLUMNS - 1) begin
      col_next++;
    end
    if (step_n > 0) step_toks[step_n-1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic token_rec_t tk(logic [CODE_W-1:0] code, int len, int col, int last);
    return '{code, LEN_W'(len), COL_W'(col), 1'(last)};
  endfunction

  function automatic char_row_t pr(logic [CH_W-1:0] c, int eol);
    return '{c, 1'(eol), 1'b0, 2'd0, {NO_TOK, NO_TOK, NO_TOK}};
  endfunction

  function automatic char_row_t kr(logic [CH_W-1:0] c, int eol, int n,
                                   token_rec_t t0, token_rec_t t1, token_rec_t t2);
    return '{c, 1'(eol), 1'b1, 2'(n), {t2, t1, t0}};
  endfunction

  // offer one character, wait for it to be taken, then book its tokens
  task automatic send_row(char_row_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      chars_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    chars_if.valid       <= 1'b1;
    chars_if.ch          <= r.ch;
    chars_if.end_of_line <= r.eol;
    do @(posedge clk_i); while (!chars_if.ready);
    items_sent++;
    scan_char(r.ch, r.eol);
    if (r.known) begin
      for (int i = 0; i < r.n; i++) tokens_owed.push_back(r.toks[i]);
    end else begin
      for (int i = 0; i < step_n; i++) tokens_owed.push_back(step_toks[i]);
    end
  endtask

  task automatic put_char(logic [CH_W-1:0] c);
    send_row(pr(c, eol_pct != 0 && $urandom_range(0, 99) < eol_pct));
  endtask

  function automatic logic [CH_W-1:0] rand_word_char();
    case ($urandom_range(0, 3))
      0:       return CH_W'($urandom_range("a", "z"));
      1:       return CH_W'($urandom_range("A", "Z"));
      2:       return CH_W'($urandom_range("0", "9"));
      default: return "_";
    endcase
  endfunction

  // one lexeme-shaped burst: mostly well-formed tokens, some noise
  task automatic send_piece();
    int    r;
    int    n;
    string w;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      // keyword, sometimes one short or one long
      w = keyword_text[$urandom_range(0, NUM_KEYS-1)];
      n = $urandom_range(0, 3);
      for (int i = 0; i < w.len() - (n == 0 ? 1 : 0); i++) put_char(w[i]);
      if (n == 1) put_char(rand_word_char());
    end else if (r < 35) begin
      put_char(CH_W'($urandom_range("a", "z")));
      repeat ($urandom_range(0, 6)) put_char(rand_word_char());
    end else if (r < 55) begin
      repeat ($urandom_range(1, 3)) put_char(CH_W'($urandom_range("0", "9")));
      n = $urandom_range(0, 3);
      if (n != 0) put_char(".");
      if (n == 1 || n == 3)
        repeat ($urandom_range(1, 2)) put_char(CH_W'($urandom_range("0", "9")));
      if (n == 3) put_char(".");
    end else if (r < 73) begin
      put_char(odd_set[$urandom_range(0, odd_set.len() - 1)]);
    end else if (r < 85) begin
      n = $urandom_range(9, 14);
      put_char(n == 14 ? 8'd32 : CH_W'(n));
    end else begin
      put_char(CH_W'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 40) put_char(" ");
  endtask

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string what, token_rec_t want, token_rec_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $write("%0t: %s: expected code=%0d len=%0d col=%0d last=%0d, ",
             $time, what, want.code, want.length, want.column, want.last);
      $display("got code=%0d len=%0d col=%0d last=%0d",
               got.code, got.length, got.column, got.last);
    end
  endtask

  task automatic check_token();
    token_rec_t got;
    token_rec_t want;
    got = '{tokens_if.token_code, tokens_if.token_length, tokens_if.start_column,
            tokens_if.last};
    if (tokens_owed.size() == 0) begin
      note_mismatch("unexpected token", NO_TOK, got);
    end else begin
      want = tokens_owed.pop_front();
      if (got.code !== want.code || got.length !== want.length ||
          got.column !== want.column || got.last !== want.last)
        note_mismatch("token mismatch", want, got);
    end
  endtask

  // receiver: random stalls, plus a long hold-off when the main flow asks for one
  always @(posedge clk_i) begin
    if (tokens_if.valid && tokens_if.ready) check_token();
    if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      tokens_if.ready <= 1'b0;
    end else begin
      tokens_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- main flow

  char_row_t directed [25];

  initial begin
    chars_if.valid       = 1'b0;
    chars_if.ch          = '0;
    chars_if.end_of_line = 1'b0;
    send_idle_pct  = 19;
    recv_stall_pct = 81;

    // "+", tab-ended "main", held point before a letter, point after a word,
    // high byte, second point, held point at end of line, "int", unknowns,
    // and one character closing three tokens at once
    directed[0]  = kr("+", 0, 1, tk(CODE_ADD, 1, 0, 1), NO_TOK, NO_TOK);
    directed[1]  = pr("m", 0);
    directed[2]  = pr("a", 0);
    directed[3]  = pr("i", 0);
    directed[4]  = pr("n", 0);
    directed[5]  = kr(8'd9, 0, 1, tk(CODE_KEY_MAIN, 4, 1, 1), NO_TOK, NO_TOK);
    directed[6]  = pr("1", 0);
    directed[7]  = pr(".", 0);
    directed[8]  = kr("x", 0, 2, tk(CODE_CONST, 1, 6, 0), tk(CODE_DOT, 1, 7, 1), NO_TOK);
    directed[9]  = kr(".", 0, 2, tk(CODE_IDENT, 1, 8, 0), tk(CODE_DOT, 1, 9, 1), NO_TOK);
    directed[10] = kr(8'hFF, 0, 1, tk(CODE_UNKNOWN, 1, 10, 1), NO_TOK, NO_TOK);
    directed[11] = pr("9", 0);
    directed[12] = pr(".", 0);
    directed[13] = pr("5", 0);
    directed[14] = kr(".", 0, 2, tk(CODE_CONST, 3, 11, 0), tk(CODE_DOT, 1, 14, 1), NO_TOK);
    directed[15] = pr("7", 0);
    directed[16] = kr(".", 1, 2, tk(CODE_CONST, 1, 15, 0), tk(CODE_DOT, 1, 16, 1), NO_TOK);
    directed[17] = pr("i", 0);
    directed[18] = pr("n", 0);
    directed[19] = kr("t", 1, 1, tk(CODE_KEY_INT, 3, 0, 1), NO_TOK, NO_TOK);
    directed[20] = kr(8'h00, 0, 1, tk(CODE_UNKNOWN, 1, 0, 1), NO_TOK, NO_TOK);
    directed[21] = kr("Z", 1, 1, tk(CODE_UNKNOWN, 1, 1, 1), NO_TOK, NO_TOK);
    directed[22] = pr("3", 0);
    directed[23] = pr(".", 0);
    directed[24] = kr("+", 1, 3, tk(CODE_CONST, 1, 0, 0), tk(CODE_DOT, 1, 1, 0),
                      tk(CODE_ADD, 1, 2, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_row(directed[i]);

    while (items_sent < 55) send_piece();

    send_idle_pct  = 81;
    recv_stall_pct = 19;
    while (items_sent < 90) send_piece();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // receiver holds off while one-token items keep coming, so the queue fills
    hold_req++;
    repeat (24) send_row(pr(";", 0));

    // one long constant: the held point and the digit after it carry the
    // length past MAX_LEXEME, so it saturates
    eol_pct = 0;
    put_char(" ");
    repeat (63) put_char(CH_W'($urandom_range("0", "9")));
    put_char(".");
    repeat (2) put_char(CH_W'($urandom_range("0", "9")));
    send_row(pr("a", 1));

    chars_if.valid <= 1'b0;
    while (tokens_owed.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
